### rtl/srg_pkg.sv
// Shared types and constants for the servo ramp generator.
package srg_pkg;

    // Field widths
    localparam int NUM_CH    = 4;
    localparam int CH_W      = 2;
    localparam int POS_W     = 11;
    localparam int PCT_W     = 7;
    localparam int LEN_W     = 16;
    localparam int DLY_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Parameter defaults
    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_TIME_BITS = 32;

    // Percent of full range, and centiseconds per second
    localparam int PCT_FULL   = 100;
    localparam int CS_PER_SEC = 100;

    // Request codes
    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Register reset values
    localparam logic [POS_W-1:0] LOW_RST  = '0;
    localparam logic [POS_W-1:0] HIGH_RST = '1;

    typedef struct packed {
        logic             req_type;
        logic [CH_W-1:0]  channel;
        logic [POS_W-1:0] start_position;
        logic [PCT_W-1:0] target_percent;
        logic [LEN_W-1:0] duration_cs;
        logic [DLY_W-1:0] delay_seconds;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] position_0;
        logic [POS_W-1:0] position_1;
        logic [POS_W-1:0] position_2;
        logic [POS_W-1:0] position_3;
        logic             drive_0;
        logic             drive_1;
        logic             drive_2;
        logic             drive_3;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic            cmd_load;
        logic            tick;
        logic            eval;
        logic            mul0;
        logic            mul1;
        logic            div_step;
        logic            store;
        logic            publish;
        logic [CH_W-1:0] ch;
    } t_ctl;

endpackage

### rtl/srg_ctrl.sv
// Sequencer for the servo ramp generator: handshakes and per-channel steps.
module srg_ctrl
    import srg_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_req_type,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_ctl o_ctl
);

    localparam int BIT_W = $clog2(POS_W);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_MUL0  = 7'b0000100,
        ST_MUL1  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_STORE = 7'b0100000,
        ST_PUB   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic            r_ovalid, n_ovalid;
    logic            w_in_xfer;
    logic            w_out_free;

    assign w_in_xfer  = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ovalid;

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_bit    = r_bit;
        n_ovalid = r_ovalid && i_stall;
        o_ctl    = '0;
        o_ctl.ch = r_ch;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_req_type == REQ_TICK) begin
                        o_ctl.tick = 1'b1;
                        n_ch       = '0;
                        n_state    = ST_EVAL;
                    end else begin
                        o_ctl.cmd_load = 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                o_ctl.eval = 1'b1;
                n_state    = ST_MUL0;
            end
            ST_MUL0: begin
                o_ctl.mul0 = 1'b1;
                n_state    = ST_MUL1;
            end
            ST_MUL1: begin
                o_ctl.mul1 = 1'b1;
                n_bit      = BIT_W'(POS_W - 1);
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                n_bit          = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_ctl.store = 1'b1;
                if (r_ch == CH_W'(CHANNELS - 1)) begin
                    n_state = ST_PUB;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_PUB: begin
                // wait for the output register to be free
                if (w_out_free) begin
                    o_ctl.publish = 1'b1;
                    n_ovalid      = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ch     <= '0;
            r_bit    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_bit    <= n_bit;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

### rtl/srg_datapath.sv
// Channel state, time counter, interpolation arithmetic and output register.
module srg_datapath
    import srg_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  t_req                 i_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data,
    output t_rsp                 o_data
);

    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEN_W = LEN_W + PCT_W;        // 100 * duration
    localparam int DLT_W = POS_W + 9;            // signed target minus origin, times 100
    localparam int NUM_W = DLT_W + LEN_W + 1;    // signed numerator
    localparam int OD_W  = POS_W + DEN_W;        // origin * denominator
    localparam int DSH_W = DEN_W + POS_W - 1;    // denominator aligned to top quotient bit
    localparam int DCS_W = DLY_W + PCT_W;        // delay in centiseconds

    // Channel count, one bit wider than a channel number
    localparam logic [CH_W:0] CH_LIM = (CH_W+1)'(CHANNELS);

    // Configuration and per-channel move state
    logic [POS_W-1:0]     r_low   [CHANNELS];
    logic [POS_W-1:0]     r_high  [CHANNELS];
    logic [POS_W-1:0]     r_org   [CHANNELS];
    logic [PCT_W-1:0]     r_pct   [CHANNELS];
    logic [LEN_W-1:0]     r_len   [CHANNELS];
    logic [TIME_BITS-1:0] r_beg   [CHANNELS];
    logic [TIME_BITS-1:0] r_time;

    // Per-tick working registers
    logic [LEN_W-1:0]        r_e;
    logic                    r_drv;
    logic [DEN_W-1:0]        r_den;
    logic signed [DLT_W-1:0] r_delta;
    logic signed [NUM_W-1:0] r_num;
    logic [DSH_W-1:0]        r_dsh;
    logic [POS_W-1:0]        r_quo;
    logic [POS_W-1:0]        r_pos  [CHANNELS];
    logic                    r_drvs [CHANNELS];
    t_rsp                    r_out;

    logic [CH_W-1:0]         w_cfg_ch;
    logic [CH_IW-1:0]        w_ci;
    logic [CH_IW-1:0]        w_cmd_ci;
    logic [CH_IW-1:0]        w_cfg_ci;
    logic [PCT_W-1:0]        w_pct_sat;
    logic [DCS_W-1:0]        w_dly_cs;
    logic [TIME_BITS-1:0]    w_e;
    logic                    w_drv;
    logic signed [DLT_W-1:0] w_lo_s, w_hi_s, w_org_s, w_pct_s, w_hund;
    logic signed [DLT_W-1:0] w_delta;
    logic [OD_W-1:0]         w_od;
    logic signed [NUM_W-1:0] w_de;
    logic signed [NUM_W-1:0] w_trial;
    logic [POS_W-1:0]        w_pos4 [NUM_CH];
    logic                    w_drv4 [NUM_CH];

    assign w_cfg_ch = CH_W'(i_cfg_idx >> 1);
    assign w_ci     = i_ctl.ch[CH_IW-1:0];
    assign w_cmd_ci = i_data.channel[CH_IW-1:0];
    assign w_cfg_ci = w_cfg_ch[CH_IW-1:0];

    // Command decode: saturate percent, scale delay to centiseconds
    assign w_pct_sat = (i_data.target_percent > PCT_W'(PCT_FULL)) ?
                       PCT_W'(PCT_FULL) : i_data.target_percent;
    assign w_dly_cs  = DCS_W'(i_data.delay_seconds) * DCS_W'(CS_PER_SEC);

    // Elapsed time and drive window for the channel in work
    assign w_e   = r_time - r_beg[w_ci];
    assign w_drv = (w_e != '0) && (w_e <= TIME_BITS'(r_len[w_ci]));

    // Target*100 minus origin*100, signed
    assign w_lo_s  = $signed(DLT_W'(r_low[w_ci]));
    assign w_hi_s  = $signed(DLT_W'(r_high[w_ci]));
    assign w_org_s = $signed(DLT_W'(r_org[w_ci]));
    assign w_pct_s = $signed(DLT_W'(r_pct[w_ci]));
    assign w_hund  = $signed(DLT_W'(PCT_FULL));
    assign w_delta = w_lo_s * w_hund + (w_hi_s - w_lo_s) * w_pct_s - w_org_s * w_hund;

    // Products and restoring division trial
    assign w_od    = OD_W'(r_org[w_ci]) * OD_W'(r_den);
    assign w_de    = r_delta * $signed({1'b0, r_e});
    assign w_trial = r_num - $signed(NUM_W'(r_dsh));

    // Configuration, commands and time counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_low[c]  <= LOW_RST;
                r_high[c] <= HIGH_RST;
                r_org[c]  <= '0;
                r_pct[c]  <= '0;
                r_len[c]  <= '0;
                r_beg[c]  <= '0;
            end
        end else begin
            if (i_cfg_we && ({1'b0, w_cfg_ch} < CH_LIM)) begin
                if (i_cfg_idx[0]) begin
                    r_high[w_cfg_ci] <= i_cfg_data;
                end else begin
                    r_low[w_cfg_ci] <= i_cfg_data;
                end
            end
            if (i_ctl.cmd_load && ({1'b0, i_data.channel} < CH_LIM)) begin
                r_org[w_cmd_ci] <= i_data.start_position;
                r_pct[w_cmd_ci] <= w_pct_sat;
                r_len[w_cmd_ci] <= i_data.duration_cs;
                r_beg[w_cmd_ci] <= r_time + TIME_BITS'(w_dly_cs);
            end
            if (i_ctl.tick) begin
                r_time <= r_time + 1'b1;
            end
        end
    end

    // Interpolation sequence for one channel
    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_e     <= w_e[LEN_W-1:0];
            r_drv   <= w_drv;
            r_den   <= DEN_W'(r_len[w_ci]) * DEN_W'(PCT_FULL);
            r_delta <= w_delta;
        end
        if (i_ctl.mul0) begin
            r_num <= $signed(NUM_W'(w_od));
        end
        if (i_ctl.mul1) begin
            r_num <= r_num + w_de;
            r_dsh <= DSH_W'(r_den) << (POS_W - 1);
            r_quo <= '0;
        end
        if (i_ctl.div_step) begin
            if (w_trial >= 0) begin
                r_num <= w_trial;
                r_quo <= {r_quo[POS_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[POS_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_ctl.store) begin
            r_pos[w_ci]  <= r_drv ? r_quo : '0;
            r_drvs[w_ci] <= r_drv;
        end
        if (i_ctl.publish) begin
            r_out.position_0 <= w_pos4[0];
            r_out.position_1 <= w_pos4[1];
            r_out.position_2 <= w_pos4[2];
            r_out.position_3 <= w_pos4[3];
            r_out.drive_0    <= w_drv4[0];
            r_out.drive_1    <= w_drv4[1];
            r_out.drive_2    <= w_drv4[2];
            r_out.drive_3    <= w_drv4[3];
        end
    end

    // Unbuilt channels read as zero
    for (genvar g = 0; g < NUM_CH; g++) begin : g_out
        if (g < CHANNELS) begin : g_used
            assign w_pos4[g] = r_pos[g];
            assign w_drv4[g] = r_drvs[g];
        end else begin : g_unused
            assign w_pos4[g] = '0;
            assign w_drv4[g] = 1'b0;
        end
    end

    assign o_data = r_out;

endmodule

### rtl/servo_ramp_generator_unit.sv
// Top level of the servo ramp generator: controller and datapath.
// A move command is taken while the unit is idle and gives no result. A tick's
// result reaches the output register after each channel in turn runs
// elapsed-time and target setup, the multiply steps MUL0 and MUL1 into the
// numerator, an 11-step restoring divider that yields one position bit a
// cycle, and a store; a publish step then writes the result once the output
// register is free. The divider is shared by all channels in turn. A new
// item is taken once the previous tick's result sits in the output register,
// which holds it until transfer.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data.
module servo_ramp_generator_unit
    import srg_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_req                 i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_rsp                 o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data
);

    t_ctl w_ctl;

    // Sequencer
    srg_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_data.req_type),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_ctl      (w_ctl)
    );

    // Arithmetic and state
    srg_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_data     (o_data)
    );

endmodule
